FILE: src/ptq_pkg.sv
// Package for the priority ticket queue: opcodes, status codes, states, entry type.
// No dependencies.
package ptq_pkg;

   typedef enum logic [1:0] {
      OP_REGISTER = 2'd0,
      OP_SET_PRIO = 2'd1,
      OP_SERVE    = 2'd2,
      OP_LOOKUP   = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_DUP      = 3'd1,
      ST_NOTFOUND = 3'd2,
      ST_BADLEVEL = 3'd3,
      ST_EMPTY    = 3'd4,
      ST_FULL     = 3'd5
   } status_type;

   localparam logic [1:0] LEVEL_LOW     = 2'd0;
   localparam logic [1:0] LEVEL_INVALID = 2'd3;

   typedef struct packed {
      logic [31:0] id;
      logic [1:0]  level;
      logic [31:0] stamp;
   } entry_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SEARCH,
      S_REMOVE,
      S_INSERT,
      S_RING,
      S_RESP
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;     // capture request
      logic search;   // compare all cells, record hit
      logic remove;   // pull hit (or head) out, shift tail up
      logic insert;   // place entry in sorted slot
      logic ring;     // push served entry into ring / scan ring
      logic respond;  // present result
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic       wait_hit;
      logic       wait_full;
      logic       wait_empty;
      logic       rsp_busy;
      op_type     op;
      logic [1:0] level;
   } stat_type;

endpackage

FILE: src/ptq_ctrl.sv
// Controller for the priority ticket queue: sequences search, remove, insert, ring steps.
// Depends on ptq_pkg.
module ptq_ctrl
   import ptq_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_tvalid,
   output logic     req_tready,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff, state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:   if (req_tvalid) state_in = S_SEARCH;
         S_SEARCH: begin
            unique case (stat.op)
               OP_REGISTER:
                  state_in = (stat.wait_hit || stat.wait_full) ? S_RESP : S_INSERT;
               OP_SET_PRIO:
                  state_in = (!stat.wait_hit || stat.level == LEVEL_INVALID) ? S_RESP
                                                                               : S_REMOVE;
               OP_SERVE:  state_in = stat.wait_empty ? S_RESP : S_REMOVE;
               OP_LOOKUP: state_in = stat.wait_hit ? S_RESP : S_RING;
               default:   state_in = S_RESP;
            endcase
         end
         S_REMOVE: state_in = (stat.op == OP_SERVE) ? S_RING : S_INSERT;
         S_INSERT: state_in = S_RESP;
         S_RING:   state_in = S_RESP;
         S_RESP:   if (!stat.rsp_busy) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         S_SEARCH: cmd.search  = 1'b1;
         S_REMOVE: cmd.remove  = 1'b1;
         S_INSERT: cmd.insert  = 1'b1;
         S_RING:   cmd.ring    = 1'b1;
         S_RESP:   cmd.respond = !stat.rsp_busy;
         default:  ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

endmodule

FILE: src/ptq_datapath.sv
// Datapath for the priority ticket queue: sorted cell chain, served ring, result register.
// Depends on ptq_pkg.
module ptq_datapath
   import ptq_pkg::*;
#(
   parameter int WAIT_DEPTH   = 16,
   parameter int SERVED_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output stat_type    stat,
   input  logic [67:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata
);

   localparam int WB = $clog2(WAIT_DEPTH);
   localparam int SB = (SERVED_DEPTH > 1) ? $clog2(SERVED_DEPTH) : 1;

   // request
   op_type      op_ff;
   logic [31:0] id_ff;
   logic [1:0]  lvl_ff;
   logic [31:0] stamp_ff;

   // sorted cells
   entry_type   cell_ff [WAIT_DEPTH];
   logic [WB:0] count_ff;

   // search result
   logic [WB-1:0] hit_pos_ff;
   entry_type     work_ff;

   // served ring
   entry_type     ring_ff [SERVED_DEPTH];
   logic [SB-1:0] head_ff;
   logic [SB:0]   scount_ff;

   // result
   logic        rvalid_ff;
   status_type  rstatus_ff;
   entry_type   rentry_ff;
   logic        rserved_ff;
   logic [71:0] rsp_data_ff;

   // compare every occupied cell to the request id; lowest matching index wins
   logic          hit_in;
   logic [WB-1:0] hit_pos_in;
   always_comb begin
      hit_in     = 1'b0;
      hit_pos_in = '0;
      for (int i = WAIT_DEPTH - 1; i >= 0; i--) begin
         if ((WB+1)'(i) < count_ff && cell_ff[i].id == id_ff) begin
            hit_in     = 1'b1;
            hit_pos_in = WB'(i);
         end
      end
   end

   // insertion key: level from work entry, stamp from work entry
   logic [WAIT_DEPTH-1:0] ahead_of;
   always_comb begin
      for (int i = 0; i < WAIT_DEPTH; i++) begin
         ahead_of[i] = ((WB+1)'(i) < count_ff) &&
                       ((work_ff.level > cell_ff[i].level) ||
                        (work_ff.level == cell_ff[i].level &&
                         work_ff.stamp < cell_ff[i].stamp));
      end
   end

   // ring scan, oldest first
   logic          rhit;
   logic [SB-1:0] rpos;
   always_comb begin
      logic [SB:0] idx;
      rhit = 1'b0;
      rpos = '0;
      idx  = '0;
      for (int i = SERVED_DEPTH - 1; i >= 0; i--) begin
         idx = {1'b0, head_ff} + (SB+1)'(i);
         if (idx >= (SB+1)'(SERVED_DEPTH)) idx = idx - (SB+1)'(SERVED_DEPTH);
         if ((SB+1)'(i) < scount_ff && ring_ff[idx[SB-1:0]].id == id_ff) begin
            rhit = 1'b1;
            rpos = idx[SB-1:0];
         end
      end
   end

   logic [SB:0] tail;
   always_comb begin
      tail = {1'b0, head_ff} + scount_ff;
      if (tail >= (SB+1)'(SERVED_DEPTH)) tail = tail - (SB+1)'(SERVED_DEPTH);
   end

   assign stat.wait_hit   = hit_in;
   assign stat.wait_full  = (count_ff == (WB+1)'(WAIT_DEPTH));
   assign stat.wait_empty = (count_ff == '0);
   assign stat.rsp_busy   = rvalid_ff && !rsp_tready;
   assign stat.op         = op_ff;
   assign stat.level      = lvl_ff;

   // request capture and search
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= op_type'(req_tdata[1:0]);
         id_ff    <= req_tdata[33:2];
         lvl_ff   <= req_tdata[35:34];
         stamp_ff <= req_tdata[67:36];
      end
      if (cmd.search) begin
         hit_pos_ff <= hit_pos_in;
         if (op_ff == OP_SERVE) work_ff <= cell_ff[0];
         else if (op_ff == OP_REGISTER) work_ff <= '{id_ff, LEVEL_LOW, stamp_ff};
         else work_ff <= '{id_ff, lvl_ff, cell_ff[hit_pos_in].stamp};
      end
   end

   // cell chain: remove shifts up past the hit, insert shifts down from the slot
   always_ff @(posedge clock) begin
      if (cmd.remove) begin
         for (int i = 0; i < WAIT_DEPTH - 1; i++) begin
            if ((op_ff == OP_SERVE) || i >= hit_pos_ff) cell_ff[i] <= cell_ff[i+1];
         end
      end else if (cmd.insert) begin
         // slot 0 takes the entry when it sorts first or the chain is empty
         if (ahead_of[0] || count_ff == '0) cell_ff[0] <= work_ff;
         for (int i = 1; i < WAIT_DEPTH; i++) begin
            if (ahead_of[i] || (WB+1)'(i) == count_ff) begin
               if (ahead_of[i-1]) cell_ff[i] <= cell_ff[i-1];
               else cell_ff[i] <= work_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.remove) begin
         count_ff <= count_ff - 1'b1;
      end else if (cmd.insert) begin
         count_ff <= count_ff + 1'b1;
      end
   end

   // served ring
   always_ff @(posedge clock) begin
      if (cmd.ring && op_ff == OP_SERVE) begin
         if (scount_ff < (SB+1)'(SERVED_DEPTH)) ring_ff[tail[SB-1:0]] <= work_ff;
         else ring_ff[head_ff] <= work_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff   <= '0;
         scount_ff <= '0;
      end else if (cmd.ring && op_ff == OP_SERVE) begin
         if (scount_ff < (SB+1)'(SERVED_DEPTH)) begin
            scount_ff <= scount_ff + 1'b1;
         end else if (head_ff == SB'(SERVED_DEPTH - 1)) begin
            head_ff <= '0;
         end else begin
            head_ff <= head_ff + 1'b1;
         end
      end
   end

   // result register: decided in the search step, or in the ring step for a lookup that hits there
   always_ff @(posedge clock) begin
      if (cmd.search) begin
         rserved_ff <= 1'b0;
         rentry_ff  <= '0;
         rstatus_ff <= ST_OK;
         case (op_ff)
            OP_REGISTER: begin
               if (hit_in) rstatus_ff <= ST_DUP;
               else if (count_ff == (WB+1)'(WAIT_DEPTH)) rstatus_ff <= ST_FULL;
               else rentry_ff <= '{id_ff, LEVEL_LOW, stamp_ff};
            end
            OP_SET_PRIO: begin
               if (!hit_in) rstatus_ff <= ST_NOTFOUND;
               else if (lvl_ff == LEVEL_INVALID) rstatus_ff <= ST_BADLEVEL;
               else rentry_ff <= '{id_ff, lvl_ff, cell_ff[hit_pos_in].stamp};
            end
            OP_SERVE: begin
               if (count_ff == '0) rstatus_ff <= ST_EMPTY;
               else rentry_ff <= cell_ff[0];
            end
            default: begin
               if (hit_in) rentry_ff <= cell_ff[hit_pos_in];
               else rstatus_ff <= ST_NOTFOUND;
            end
         endcase
      end else if (cmd.ring && op_ff == OP_LOOKUP) begin
         if (rhit) begin
            rstatus_ff <= ST_OK;
            rentry_ff  <= ring_ff[rpos];
            rserved_ff <= 1'b1;
         end
      end
   end

   // output beat register: holds the beat while the next request works
   always_ff @(posedge clock) begin
      if (cmd.respond) begin
         rsp_data_ff <= {2'b0, rserved_ff, rentry_ff.stamp, rentry_ff.level,
                         rentry_ff.id, rstatus_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rvalid_ff <= 1'b0;
      else if (cmd.respond) rvalid_ff <= 1'b1;
      else if (rsp_tready) rvalid_ff <= 1'b0;
   end

   assign rsp_tvalid = rvalid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

FILE: src/priority_ticket_queue.sv
// Top level of the priority ticket queue: joins controller and datapath.
// Depends on ptq_pkg, ptq_ctrl, ptq_datapath.
//
// Tickets wait in a chain of cells sorted by level (highest first) then stamp
// (oldest first); served tickets go to a ring of SERVED_DEPTH entries. One
// request gives one response. States per request: search then response for
// rejects and for lookups that hit in the waiting table; search, insert,
// response for register; search, ring, response for lookups that go on to
// the served ring; search, remove, ring, response for serve; search, remove,
// insert, response for set priority. The sequencer handles one request
// at a time and the cell chain does one search, one shift-out or one
// shift-in per cycle. A response beat waits in an output register; a
// further response is held back only while that beat is still not taken.
module priority_ticket_queue
   import ptq_pkg::*;
#(
   parameter int WAIT_DEPTH   = 16,
   parameter int SERVED_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // operation[1:0], ticket_id[33:2], level_code[35:34], arrival_stamp[67:36]
   input  logic [71:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // status[2:0], out_id[34:3], out_level[36:35], out_stamp[68:37], in_served[69]
   output logic [71:0] rsp_tdata
);

   cmd_type  cmd;
   stat_type stat;

   ptq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   ptq_datapath #(
      .WAIT_DEPTH   (WAIT_DEPTH),
      .SERVED_DEPTH (SERVED_DEPTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_tdata  (req_tdata[67:0]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
